// File: src/pam_header_parser_top_assert.svh
// Assertion macros shared by the header parser. The clock is clk and the
// reset is arst_n in every scope that uses them.
`ifndef PAM_HEADER_PARSER_TOP_ASSERT_SVH
`define PAM_HEADER_PARSER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PAM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PAM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: src/pamhp_pkg.sv
package pamhp_pkg;

	localparam int VALUE_BITS_DEF    = 16;
	localparam int POSITION_BITS_DEF = 16;
	localparam int OUT_W             = 16;
	localparam int BYTE_W            = 8;
	localparam int NKW               = 6;
	localparam int COL_W             = 4;
	localparam int TEXT_D            = 16;
	localparam int MAGIC_LEN         = 3;
	localparam logic [COL_W-1:0] GRAY_LEN = 4'd9;
	localparam logic [COL_W-1:0] RGB_LEN  = 4'd3;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_WIDTH,
		KIND_HEIGHT,
		KIND_DEPTH,
		KIND_MAXVAL,
		KIND_TUPL,
		KIND_END
	} kind_t;

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_DIGITS,
		PH_NEG,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		TC_GRAY  = 2'd0,
		TC_RGB   = 2'd1,
		TC_OTHER = 2'd2
	} tclass_t;

	localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
	localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	localparam logic [BYTE_W-1:0] MAGIC [4] = '{"P", "7", 8'h0A, 8'h00};

	// Keyword order sets the field kind: entry k selects kind k+1.
	localparam logic [BYTE_W-1:0] KW_TEXT [NKW][TEXT_D] = '{
		'{0:"W", 1:"I", 2:"D", 3:"T", 4:"H", 5:" ", default:8'h00},
		'{0:"H", 1:"E", 2:"I", 3:"G", 4:"H", 5:"T", 6:" ", default:8'h00},
		'{0:"D", 1:"E", 2:"P", 3:"T", 4:"H", 5:" ", default:8'h00},
		'{0:"M", 1:"A", 2:"X", 3:"V", 4:"A", 5:"L", 6:" ", default:8'h00},
		'{0:"T", 1:"U", 2:"P", 3:"L", 4:"T", 5:"Y", 6:"P", 7:"E", 8:" ",
			default:8'h00},
		'{0:"E", 1:"N", 2:"D", 3:"H", 4:"D", 5:"R", default:8'h00}
	};
	localparam logic [COL_W-1:0] KW_LEN [NKW] = '{4'd6, 4'd7, 4'd6, 4'd7, 4'd9, 4'd6};

	localparam logic [BYTE_W-1:0] GRAY_TEXT [TEXT_D] = '{
		0:"G", 1:"R", 2:"A", 3:"Y", 4:"S", 5:"C", 6:"A", 7:"L", 8:"E",
		default:8'h00
	};
	localparam logic [BYTE_W-1:0] RGB_TEXT [TEXT_D] = '{
		0:"R", 1:"G", 2:"B", default:8'h00
	};

	typedef struct packed {
		logic [BYTE_W-1:0] byte_in;
		logic              first;
		logic              last;
	} byte_item_t;

	typedef struct packed {
		logic             ok;
		logic [OUT_W-1:0] width_out;
		logic [OUT_W-1:0] height_out;
		logic [OUT_W-1:0] depth_out;
		logic [OUT_W-1:0] maxval_out;
		logic [1:0]       tuple_class;
		logic [OUT_W-1:0] data_offset;
	} hdr_result_t;

	typedef struct packed {
		logic load;
		logic finished;
	} parse_stat_t;

	function automatic logic is_blank(input logic [BYTE_W-1:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
	endfunction

endpackage

// File: src/pam_byte_if.sv
interface pam_byte_if;
	logic                        valid;
	logic                        ready;
	logic [pamhp_pkg::BYTE_W-1:0] byte_in;
	logic                        first;
	logic                        last;

	modport source(output valid, output byte_in, output first, output last, input ready);
	modport sink(input valid, input byte_in, input first, input last, output ready);
endinterface

// File: src/pam_hdr_if.sv
interface pam_hdr_if;
	logic                        valid;
	logic                        ready;
	logic                        ok;
	logic [pamhp_pkg::OUT_W-1:0] width_out;
	logic [pamhp_pkg::OUT_W-1:0] height_out;
	logic [pamhp_pkg::OUT_W-1:0] depth_out;
	logic [pamhp_pkg::OUT_W-1:0] maxval_out;
	logic [1:0]                  tuple_class;
	logic [pamhp_pkg::OUT_W-1:0] data_offset;

	modport source(output valid, output ok, output width_out, output height_out,
		output depth_out, output maxval_out, output tuple_class, output data_offset,
		input ready);
	modport sink(input valid, input ok, input width_out, input height_out,
		input depth_out, input maxval_out, input tuple_class, input data_offset,
		output ready);
endinterface

// File: src/pamhp_in_stage.sv
module pamhp_in_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pamhp_pkg::byte_item_t in_item,
	input  logic                  adv,
	output logic                  valid_s1,
	output pamhp_pkg::byte_item_t item_s1
);
	import pamhp_pkg::*;

	// The stage refills in the same cycle that its byte moves on.
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// File: src/pamhp_parser.sv
module pamhp_parser #(
	parameter int VALUE_BITS    = pamhp_pkg::VALUE_BITS_DEF,
	parameter int POSITION_BITS = pamhp_pkg::POSITION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  pamhp_pkg::byte_item_t  item,
	output logic                   adv,
	input  logic                   res_ready,
	output logic                   res_valid,
	output pamhp_pkg::hdr_result_t res,
	output pamhp_pkg::parse_stat_t stat
);
	import pamhp_pkg::*;

	localparam int PROD_W = VALUE_BITS + 4;
	localparam logic [VALUE_BITS-1:0]    VMAX = '1;
	localparam logic [POSITION_BITS-1:0] PMAX = '1;

	logic [POSITION_BITS-1:0] pos_q, n_pos;
	logic [COL_W-1:0]         col_q, n_col;
	logic [NKW-1:0]           cand_q, n_cand;
	kind_t                    kind_q, n_kind;
	logic [VALUE_BITS-1:0]    acc_q, n_acc;
	phase_t                   phase_q, n_phase;
	logic [VALUE_BITS-1:0]    wv_q, n_wv, hv_q, n_hv, dv_q, n_dv, mv_q, n_mv;
	logic [COL_W-1:0]         tm_q, n_tm;
	tclass_t                  tc_q, n_tc;
	logic                     fin_q, n_fin;
	logic                     emit, emit_ok;
	logic                     res_valid_q;
	hdr_result_t              res_q, n_res;

	// A byte leaves the input register when the result register is free or drains.
	assign adv = item_valid && (!res_valid_q || res_ready);

	always_comb begin
		logic [POSITION_BITS-1:0] cur;
		logic [BYTE_W-1:0]        c;
		logic                     dig;
		logic [3:0]               dval;
		logic [PROD_W-1:0]        prod;
		logic [VALUE_BITS-1:0]    v;
		logic                     done;
		logic                     found;

		n_pos = pos_q;
		n_col = col_q;
		n_cand = cand_q;
		n_kind = kind_q;
		n_acc = acc_q;
		n_phase = phase_q;
		n_wv = wv_q;
		n_hv = hv_q;
		n_dv = dv_q;
		n_mv = mv_q;
		n_tm = tm_q;
		n_tc = tc_q;
		n_fin = fin_q;
		emit = 1'b0;
		emit_ok = 1'b0;
		done = 1'b0;
		found = 1'b0;
		prod = '0;
		v = '0;

		c = item.byte_in;
		dig = c >= CH_ZERO && c <= CH_NINE;
		dval = 4'(c - CH_ZERO);

		// A first byte restarts from the reset state.
		if (item.first) begin
			n_pos = '0;
			n_col = '0;
			n_cand = '1;
			n_kind = KIND_NONE;
			n_acc = '0;
			n_phase = PH_SKIP;
			n_wv = '0;
			n_hv = '0;
			n_dv = '0;
			n_mv = '0;
			n_tm = '0;
			n_tc = TC_OTHER;
			n_fin = 1'b0;
		end

		cur = n_pos;
		if (!n_fin) begin
			if (n_pos != PMAX) begin
				n_pos = n_pos + 1'b1;
			end

			if (cur < POSITION_BITS'(MAGIC_LEN)) begin
				if (MAGIC[cur[1:0]] != c) begin
					n_fin = 1'b1;
					emit = 1'b1;
					done = 1'b1;
				end
			end else if (c == CH_NL) begin
				v = (n_phase == PH_NEG) ? '0 : n_acc;
				case (n_kind)
					KIND_WIDTH:  n_wv = v;
					KIND_HEIGHT: n_hv = v;
					KIND_DEPTH:  n_dv = v;
					KIND_MAXVAL: n_mv = v;
					KIND_TUPL: begin
						if (n_cand[0] && n_tm == GRAY_LEN) begin
							n_tc = TC_GRAY;
						end else if (n_cand[1] && n_tm == RGB_LEN) begin
							n_tc = TC_RGB;
						end else begin
							n_tc = TC_OTHER;
						end
					end
					KIND_END: begin
						n_fin = 1'b1;
						emit = 1'b1;
						emit_ok = 1'b1;
						done = 1'b1;
					end
					default: ;
				endcase
				if (!done) begin
					n_col = '0;
					n_cand = '1;
					n_kind = KIND_NONE;
					n_acc = '0;
					n_phase = PH_SKIP;
					n_tm = '0;
				end
			end else if (n_kind == KIND_TUPL) begin
				if (n_tm >= GRAY_LEN || GRAY_TEXT[n_tm] != c) begin
					n_cand[0] = 1'b0;
				end
				if (n_tm >= RGB_LEN || RGB_TEXT[n_tm] != c) begin
					n_cand[1] = 1'b0;
				end
				if (n_tm != '1) begin
					n_tm = n_tm + 1'b1;
				end
			end else if (n_kind != KIND_NONE) begin
				if (n_kind != KIND_END) begin
					case (n_phase)
						PH_SKIP: begin
							if (is_blank(c)) begin
								n_phase = PH_SKIP;
							end else if (c == CH_PLUS) begin
								n_phase = PH_DIGITS;
							end else if (c == CH_MINUS) begin
								n_phase = PH_NEG;
							end else if (dig) begin
								n_acc = VALUE_BITS'(dval);
								n_phase = PH_DIGITS;
							end else begin
								n_phase = PH_DONE;
							end
						end
						PH_DIGITS: begin
							if (dig) begin
								prod = PROD_W'({n_acc, 3'b000}) + PROD_W'({n_acc, 1'b0})
									+ PROD_W'(dval);
								n_acc = (prod > PROD_W'(VMAX)) ? VMAX : VALUE_BITS'(prod);
							end else begin
								n_phase = PH_DONE;
							end
						end
						PH_NEG: begin
							if (!dig) begin
								n_phase = PH_DONE;
							end
						end
						default: ;
					endcase
				end
			end else begin
				// Keyword match at the current column; a line that starts with
				// a comment mark simply matches nothing.
				for (int k = 0; k < NKW; k++) begin
					if (n_cand[k] && !found) begin
						if (n_col >= KW_LEN[k] || KW_TEXT[k][n_col] != c) begin
							n_cand[k] = 1'b0;
						end else if (5'(n_col) + 5'd1 == 5'(KW_LEN[k])) begin
							n_kind = kind_t'(3'(k + 1));
							found = 1'b1;
							if (n_kind == KIND_TUPL) begin
								n_cand = NKW'(3);
							end
						end
					end
				end
				if (n_col != '1) begin
					n_col = n_col + 1'b1;
				end
			end

			if (!done && item.last) begin
				n_fin = 1'b1;
				emit = 1'b1;
			end
		end

		n_res.ok = emit_ok;
		n_res.width_out = emit_ok ? OUT_W'(n_wv) : '0;
		n_res.height_out = emit_ok ? OUT_W'(n_hv) : '0;
		n_res.depth_out = emit_ok ? OUT_W'(n_dv) : '0;
		n_res.maxval_out = emit_ok ? OUT_W'(n_mv) : '0;
		n_res.tuple_class = emit_ok ? n_tc : TC_OTHER;
		n_res.data_offset = emit_ok ? OUT_W'(n_pos) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			col_q <= '0;
			cand_q <= '1;
			kind_q <= KIND_NONE;
			acc_q <= '0;
			phase_q <= PH_SKIP;
			wv_q <= '0;
			hv_q <= '0;
			dv_q <= '0;
			mv_q <= '0;
			tm_q <= '0;
			tc_q <= TC_OTHER;
			fin_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				pos_q <= n_pos;
				col_q <= n_col;
				cand_q <= n_cand;
				kind_q <= n_kind;
				acc_q <= n_acc;
				phase_q <= n_phase;
				wv_q <= n_wv;
				hv_q <= n_hv;
				dv_q <= n_dv;
				mv_q <= n_mv;
				tm_q <= n_tm;
				tc_q <= n_tc;
				fin_q <= n_fin;
			end
			if (adv && emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_q <= n_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;
	assign stat.load = adv && emit;
	assign stat.finished = fin_q;

endmodule

// File: src/pam_header_parser_top.sv
// PAM (P7) header parser. Bytes of an image buffer arrive one per transaction
// on the byte channel, with first marking the byte that starts a new buffer and
// last marking its final byte. The block checks the "P7" magic line, then reads
// WIDTH, HEIGHT, DEPTH, MAXVAL and TUPLTYPE lines and stops at the ENDHDR line.
// One result transaction leaves on the header channel per buffer: ok high with
// the four values (0 where absent, saturated at the largest value), the tuple
// class (GRAYSCALE, RGB or other) and the offset of the first byte after the
// ENDHDR line; or ok low with all fields zero and the class set to other, given
// at the first byte that breaks the magic or at the last byte when no ENDHDR came.
// Bytes after a result are dropped until the next byte marked first. The block
// takes one byte every clock cycle while the result register is free or
// drains. A byte goes through an input register and is then parsed, and a
// result is written into the result register. Input ready follows output
// ready combinationally only while a result is held.

`include "pam_header_parser_top_assert.svh"

module pam_header_parser_top #(
	parameter int VALUE_BITS    = pamhp_pkg::VALUE_BITS_DEF,
	parameter int POSITION_BITS = pamhp_pkg::POSITION_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	pam_byte_if.sink   byte_ch,
	pam_hdr_if.source  hdr_ch
);
	import pamhp_pkg::*;

	byte_item_t  in_item;
	byte_item_t  item_s1;
	logic        valid_s1;
	logic        adv;
	logic        res_valid;
	hdr_result_t res;
	parse_stat_t stat;

	assign in_item.byte_in = byte_ch.byte_in;
	assign in_item.first = byte_ch.first;
	assign in_item.last = byte_ch.last;

	// Input register: holds one byte transaction ahead of the parser.
	pamhp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (byte_ch.valid),
		.in_ready (byte_ch.ready),
		.in_item  (in_item),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Parser: all header state, the per-byte update and the result register.
	pamhp_parser #(
		.VALUE_BITS    (VALUE_BITS),
		.POSITION_BITS (POSITION_BITS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (item_s1),
		.adv        (adv),
		.res_ready  (hdr_ch.ready),
		.res_valid  (res_valid),
		.res        (res),
		.stat       (stat)
	);

	assign hdr_ch.valid = res_valid;
	assign hdr_ch.ok = res.ok;
	assign hdr_ch.width_out = res.width_out;
	assign hdr_ch.height_out = res.height_out;
	assign hdr_ch.depth_out = res.depth_out;
	assign hdr_ch.maxval_out = res.maxval_out;
	assign hdr_ch.tuple_class = res.tuple_class;
	assign hdr_ch.data_offset = res.data_offset;

	// Every result ends the parse of its buffer.
	`PAM_ASSERT_NEXT(a_result_finishes, stat.load, stat.finished, "result left parse open")
	// A finished parse stays silent until a new buffer starts.
	`PAM_ASSERT_NOW(a_silent_after_finish, adv && stat.finished && !item_s1.first, !stat.load, "result after finish")
	// A byte waiting in the input register is neither lost nor overwritten.
	`PAM_ASSERT_NEXT(a_input_held, valid_s1 && !adv, valid_s1 && $stable(item_s1), "input byte lost")

endmodule
